// ===== hw/rtl/lis_pkg.sv =====
// ----------------------------------------------------------------------------
// lis_pkg
// Shared types and constants for the longest increasing subsequence block.
// ----------------------------------------------------------------------------
package lis_pkg;

  localparam int VALUE_BITS = 32;
  localparam int RUN_W      = 11;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] sample_value;
    logic                         start_req;
  } lis_in_t;

  typedef struct packed {
    logic [RUN_W-1:0] run_length;
    logic             overflow;
  } lis_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } lis_state_t;

endpackage

// ===== hw/rtl/longest_increasing_subsequence.sv =====
// ----------------------------------------------------------------------------
// longest_increasing_subsequence
// Streaming tracker of the longest strictly increasing subsequence length.
// ----------------------------------------------------------------------------
// Each input item carries a signed sample and a start flag. The block keeps
// a table of tails in a RAM (entry k = smallest value ending a strictly
// increasing run of length k+1) and places each sample by binary search at
// the first tail not less than it, either replacing that tail or appending.
// One result item follows every input item: the current run length and a
// sticky overflow flag (set when a full table had to drop an extension,
// cleared by start_req). The idle state accepts an item, the search state
// takes one search step per RAM read, ceil(log2(L+1)) steps at most for a
// table of L entries, and the finish state writes back and loads the result,
// waiting only while the previous result still waits unaccepted. The search
// loop is bound by the RAM's registered read. Items are processed one at a
// time; the next item is taken while a result still waits on the output
// register. The RAM needs no clearing after reset: only entries below the
// current length are ever read.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lis_pkg::lis_in_t  in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output lis_pkg::lis_out_t out_item
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int LEN_W = $clog2(MAX_ENTRIES + 1);
  localparam int VW    = lis_pkg::VALUE_BITS;

  lis_pkg::lis_state_t state_r, state_nxt;

  // table_length and sticky overflow
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             ovf_r, ovf_nxt;

  // search window [lo, hi) and the address in flight
  logic [LEN_W-1:0] lo_r, lo_nxt;
  logic [LEN_W-1:0] hi_r, hi_nxt;
  logic [LEN_W-1:0] mid_r, mid_nxt;
  logic [VW-1:0]    key_r, key_nxt;

  logic              out_valid_r, out_valid_nxt;
  lis_pkg::lis_out_t out_item_r, out_item_nxt;

  // RAM ports
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  logic [VW-1:0]    ram_rdata;

  // search step helpers
  logic [LEN_W-1:0] len_acc;
  logic [LEN_W-1:0] lo_s, hi_s;
  logic             tail_less;

  lis_ram #(
    .WIDTH(VW),
    .DEPTH(MAX_ENTRIES)
  ) u_tails (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(key_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lis_pkg::ST_IDLE;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    key_r      <= key_nxt;
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    ram_we        = 1'b0;
    ram_waddr     = lo_r[IDX_W-1:0];
    ram_raddr     = mid_r[IDX_W-1:0];
    len_acc       = in_item.start_req ? '0 : len_r;
    tail_less     = $signed(ram_rdata) < $signed(key_r);
    lo_s          = tail_less ? mid_r + LEN_W'(1) : lo_r;
    hi_s          = tail_less ? hi_r : mid_r;

    unique case (state_r)
      lis_pkg::ST_IDLE: begin
        if (in_valid) begin
          key_nxt = in_item.sample_value;
          len_nxt = len_acc;
          if (in_item.start_req) begin
            ovf_nxt = 1'b0;
          end
          lo_nxt    = '0;
          hi_nxt    = len_acc;
          mid_nxt   = len_acc >> 1;
          ram_raddr = mid_nxt[IDX_W-1:0];
          // empty table: position zero, nothing to search
          state_nxt = (len_acc == '0) ? lis_pkg::ST_FINISH : lis_pkg::ST_SEARCH;
        end
      end

      lis_pkg::ST_SEARCH: begin
        // ram_rdata holds the tail at mid_r
        lo_nxt    = lo_s;
        hi_nxt    = hi_s;
        mid_nxt   = lo_s + ((hi_s - lo_s) >> 1);
        ram_raddr = mid_nxt[IDX_W-1:0];
        if (lo_s == hi_s) begin
          state_nxt = lis_pkg::ST_FINISH;
        end
      end

      lis_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          if (lo_r == len_r) begin
            if (len_r < LEN_W'(MAX_ENTRIES)) begin
              ram_we    = 1'b1;
              ram_waddr = len_r[IDX_W-1:0];
              len_nxt   = len_r + LEN_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            ram_we = 1'b1;
          end
          out_valid_nxt           = 1'b1;
          out_item_nxt.run_length = lis_pkg::RUN_W'(len_nxt);
          out_item_nxt.overflow   = ovf_nxt;
          state_nxt               = lis_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lis_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == lis_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== hw/rtl/lis_ram.sv =====
// ----------------------------------------------------------------------------
// lis_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/lis_checker.sv =====
// ----------------------------------------------------------------------------
// lis_port_checker
// Port-level assertions for the longest increasing subsequence block.
// ----------------------------------------------------------------------------
module lis_port_checker #(
  parameter int MAX_ENTRIES = 1024
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input lis_pkg::lis_in_t  in_item,
  input logic              out_valid,
  input logic              out_ready,
  input lis_pkg::lis_out_t out_item
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken during a search");

  // overflow only ever shows with a full table
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.overflow |->
      out_item.run_length == lis_pkg::RUN_W'(MAX_ENTRIES))
    else $error("overflow without a full table");

  // length bounded by table depth
  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (MAX_ENTRIES < 2048) |->
      out_item.run_length <= lis_pkg::RUN_W'(MAX_ENTRIES))
    else $error("run length beyond table depth");

  // no result straight out of reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind longest_increasing_subsequence lis_port_checker #(
  .MAX_ENTRIES(MAX_ENTRIES)
) u_lis_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_item  (in_item),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_item (out_item)
);
